[rtl/acb_pkg.sv]
// ----------------------------------------------------------------------------
// acb_pkg
// shared types, constants and the square root step for the circle coverage
// blend pipeline
// ----------------------------------------------------------------------------
package acb_pkg;

  localparam int unsigned SQ_W        = 28;  // remainder / root width of the sqrt
  localparam int unsigned SQRT_STAGES = 7;   // two root digits per stage
  localparam int unsigned LATENCY     = 11;  // accept edge to result edge
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [7:0]  MAX_RADIUS  = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS      = 2'd0,
    REG_SHAPE_COLOR = 2'd1,
    REG_DRAW_MODE   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_FILL   = 1'b0,
    MODE_STROKE = 1'b1
  } draw_mode_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_pair_t;

  typedef struct packed {
    logic            valid;
    logic [15:0]     dest;
    sqrt_pair_t      acc;
  } sqrt_beat_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] dest;
    logic [7:0]  cov;
  } cov_beat_t;

  // one digit of the bitwise square root; k selects the trial bit 4^k
  function automatic sqrt_pair_t sqrt_step(input sqrt_pair_t cur, input logic [3:0] k);
    logic [SQ_W-1:0] bit_v;
    logic [SQ_W-1:0] trial;
    sqrt_pair_t      nxt;
    bit_v = SQ_W'(1) << {k, 1'b0};
    trial = cur.root + bit_v;
    if (cur.rem >= trial) begin
      nxt.rem  = cur.rem - trial;
      nxt.root = (cur.root >> 1) + bit_v;
    end else begin
      nxt.rem  = cur.rem;
      nxt.root = cur.root >> 1;
    end
    return nxt;
  endfunction

endpackage

[rtl/acb_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// acb_sqrt_stage
// one register stage of the square root pipeline, resolves two root digits
// ----------------------------------------------------------------------------
module acb_sqrt_stage
  import acb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] step_hi,
  input  sqrt_beat_t in_beat,
  output sqrt_beat_t out_beat
);

  sqrt_pair_t mid;
  sqrt_pair_t fin;

  always_comb begin
    mid = sqrt_step(in_beat.acc, step_hi);
    fin = sqrt_step(mid, step_hi - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else begin
      out_beat.valid <= in_beat.valid;
    end
    out_beat.dest <= in_beat.dest;
    out_beat.acc  <= fin;
  end

endmodule

[rtl/acb_coverage.sv]
// ----------------------------------------------------------------------------
// acb_coverage
// turns the pixel distance into fill ramp or stroke tent coverage
// ----------------------------------------------------------------------------
module acb_coverage
  import acb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] radius,
  input  logic       draw_mode,
  input  sqrt_beat_t in_beat,
  output cov_beat_t  out_beat
);

  logic [12:0]        pix_dist;
  logic [11:0]        rq;
  logic signed [13:0] delta;
  logic [4:0]         ramp;
  logic [12:0]        ramp_prod;
  logic [12:0]        ad;
  logic [12:0]        tent_prod;
  logic [7:0]         cov_next;

  always_comb begin
    pix_dist = in_beat.acc.root[13:1];
    rq       = {radius, 4'b0000};
    delta    = $signed({2'b00, rq}) - $signed({1'b0, pix_dist});
    ramp     = delta[4:0] + 5'd16;
    // ramp * 255 as ramp * 256 - ramp
    ramp_prod = {ramp, 8'h00} - {8'h00, ramp};
    ad        = (pix_dist >= {1'b0, rq}) ? (pix_dist - {1'b0, rq}) : ({1'b0, rq} - pix_dist);
    tent_prod = {ad[4:0], 8'h00} - {8'h00, ad[4:0]};
    if (draw_mode == MODE_FILL) begin
      if (delta >= 14'sd16) begin
        cov_next = 8'd255;
      end else if (delta <= -14'sd16) begin
        cov_next = 8'd0;
      end else begin
        cov_next = ramp_prod[12:5];
      end
    end else begin
      if (ad > 13'd16) begin
        cov_next = 8'd0;
      end else begin
        cov_next = 8'd255 - tent_prod[11:4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else begin
      out_beat.valid <= in_beat.valid;
    end
    out_beat.dest <= in_beat.dest;
    out_beat.cov  <= cov_next;
  end

endmodule

[rtl/acb_blend.sv]
// ----------------------------------------------------------------------------
// acb_blend
// rgb565 blend of shape and framebuffer colour, multiply stage then
// rounding divide by 255 into the output registers
// ----------------------------------------------------------------------------
module acb_blend
  import acb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] shape_color,
  input  cov_beat_t   in_beat,
  output logic        done,
  output logic [15:0] out_color,
  output logic        write_pixel,
  output logic [7:0]  coverage
);

  logic [7:0]  inv_cov;
  logic        mul_valid;
  logic [7:0]  mul_cov;
  logic [12:0] r_s;
  logic [12:0] r_t;
  logic [13:0] g_s;
  logic [13:0] g_t;
  logic [12:0] b_s;
  logic [12:0] b_t;
  logic [14:0] r_sum;
  logic [14:0] g_sum;
  logic [14:0] b_sum;
  logic [14:0] r_q;
  logic [14:0] g_q;
  logic [14:0] b_q;

  assign inv_cov = 8'd255 - in_beat.cov;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= in_beat.valid;
    end
    mul_cov <= in_beat.cov;
    r_s <= 13'(shape_color[15:11]) * 13'(in_beat.cov);
    r_t <= 13'(in_beat.dest[15:11]) * 13'(inv_cov);
    g_s <= 14'(shape_color[10:5]) * 14'(in_beat.cov);
    g_t <= 14'(in_beat.dest[10:5]) * 14'(inv_cov);
    b_s <= 13'(shape_color[4:0]) * 13'(in_beat.cov);
    b_t <= 13'(in_beat.dest[4:0]) * 13'(inv_cov);
  end

  // x / 255 as (x + 1 + (x >> 8)) >> 8, exact below 2^16 - 1
  always_comb begin
    r_sum = 15'(r_s) + 15'(r_t) + 15'd127;
    g_sum = 15'(g_s) + 15'(g_t) + 15'd127;
    b_sum = 15'(b_s) + 15'(b_t) + 15'd127;
    r_q   = (r_sum + 15'd1 + (r_sum >> 8)) >> 8;
    g_q   = (g_sum + 15'd1 + (g_sum >> 8)) >> 8;
    b_q   = (b_sum + 15'd1 + (b_sum >> 8)) >> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mul_valid;
    end
    out_color   <= {r_q[4:0], g_q[5:0], b_q[4:0]};
    write_pixel <= (mul_cov != 8'd0);
    coverage    <= mul_cov;
  end

endmodule

[rtl/aa_circle_coverage_blend_unit.sv]
// ----------------------------------------------------------------------------
// aa_circle_coverage_blend_unit
// antialiased circle fill / stroke coverage and rgb565 blend, one pixel per clock
// ----------------------------------------------------------------------------
// a beat accepted at a clock edge passes the offset square registers, the square root
// stages, the ramp or tent register and the blend multiply, then leaves with done high
// throughput: one beat per clock, busy is never raised
// the receiver cannot stall, so nothing in the pipe ever waits
// reset: synchronous rst clears all valid bits and the three config registers
// ----------------------------------------------------------------------------
module aa_circle_coverage_blend_unit
  import acb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // pixel beat in
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            x_offset,
  input  logic [7:0]            y_offset,
  input  logic [15:0]           dest_color,
  // config write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result beat out
  output logic                  done,
  output logic [15:0]           out_color,
  output logic                  write_pixel,
  output logic [7:0]            coverage
);

  // config registers
  logic [7:0]  radius;
  logic [15:0] shape_color;
  logic        draw_mode;

  // stage 1: squares of the doubled half-pixel offsets
  logic [8:0]  ex;
  logic [8:0]  ey;
  logic        sq_valid;
  logic [15:0] sq_dest;
  logic [17:0] sq_x;
  logic [17:0] sq_y;
  logic [18:0] sq_sum;

  // square root pipe, entry 0 is the unregistered feed
  sqrt_beat_t  sqrt_pipe [0:SQRT_STAGES];
  cov_beat_t   cov_beat;

  // the pipe never holds off an item
  assign busy = 1'b0;

  // config writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 8'd0;
      shape_color <= 16'd0;
      draw_mode   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIUS: begin
          radius <= (cfg_data[7:0] > MAX_RADIUS) ? MAX_RADIUS : cfg_data[7:0];
        end
        REG_SHAPE_COLOR: begin
          shape_color <= cfg_data;
        end
        REG_DRAW_MODE: begin
          draw_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // distance is measured to the pixel centre, hence 2*offset + 1
  assign ex = {x_offset, 1'b1};
  assign ey = {y_offset, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= start && !busy;
    end
    sq_dest <= dest_color;
    sq_x    <= 18'(ex) * 18'(ex);
    sq_y    <= 18'(ey) * 18'(ey);
  end

  // sum scaled by 256 so the root lands in 1/32 pixel, halved later to 1/16
  assign sq_sum = 19'(sq_x) + 19'(sq_y);

  always_comb begin
    sqrt_pipe[0].valid    = sq_valid;
    sqrt_pipe[0].dest     = sq_dest;
    sqrt_pipe[0].acc.rem  = {1'b0, sq_sum, 8'h00};
    sqrt_pipe[0].acc.root = '0;
  end

  // seven stages, two digits each, trial bits 4^13 down to 4^0
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    acb_sqrt_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .step_hi  (4'(2 * SQRT_STAGES - 1 - 2 * j)),
      .in_beat  (sqrt_pipe[j]),
      .out_beat (sqrt_pipe[j+1])
    );
  end

  acb_coverage u_coverage (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .draw_mode (draw_mode),
    .in_beat   (sqrt_pipe[SQRT_STAGES]),
    .out_beat  (cov_beat)
  );

  // zero and full coverage fall out of the blend formula exactly
  acb_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .shape_color (shape_color),
    .in_beat     (cov_beat),
    .done        (done),
    .out_color   (out_color),
    .write_pixel (write_pixel),
    .coverage    (coverage)
  );

endmodule

[rtl/acb_checker.sv]
// ----------------------------------------------------------------------------
// acb_checker
// port level checks of the coverage blend unit, bound to the top level
// ----------------------------------------------------------------------------
module acb_checker
  import acb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [15:0] dest_color,
  input logic        done,
  input logic [15:0] out_color,
  input logic        write_pixel,
  input logic [7:0]  coverage
);

  // every accepted beat comes out a fixed time later
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##11 done)
    else $error("accepted beat did not produce a result");

  // no result without a beat accepted at the matching edge
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without accepted beat");

  // an uncovered pixel hands back the framebuffer colour it came with
  a_zero_cov_keeps_dest: assert property (@(posedge clk) disable iff (rst)
    done && coverage == 8'd0 |-> out_color == $past(dest_color, LATENCY))
    else $error("zero coverage changed the colour");

  a_write_matches_cov: assert property (@(posedge clk) disable iff (rst)
    done |-> write_pixel == (coverage != 8'd0))
    else $error("write flag disagrees with coverage");

endmodule

bind aa_circle_coverage_blend_unit acb_checker u_acb_checker (.*);

[tb/aa_circle_coverage_blend_unit_tb.sv]
// ----------------------------------------------------------------------------
// aa_circle_coverage_blend_unit_tb
// checks the antialiased circle coverage and rgb565 blend unit pixel by pixel:
// a behavioral predictor computes distance, fill or stroke coverage and the
// channel blend for every accepted beat, and a monitor compares each result
// beat against the oldest prediction. directed corner cases come first, then
// randomized phases that mostly hit the antialiased rim of the circle
// ----------------------------------------------------------------------------
module aa_circle_coverage_blend_unit_tb
  import acb_pkg::*;
();

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 11;
  localparam int MAX_GAP = 19;
  localparam int RANDOM_PHASES = 11;
  localparam int PIXELS_PER_PHASE = 50;
  localparam int MAX_REPORTS = 10;
  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [15:0] color;
    logic        wr;
    logic [7:0]  cov;
  } pixel_result_t;

  // clock, reset and all dut inputs start at known values
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [7:0]            x_offset = '0;
  logic [7:0]            y_offset = '0;
  logic [15:0]           dest_color = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic [15:0]           out_color;
  logic                  write_pixel;
  logic [7:0]            coverage;

  // shadow copy of the configuration registers
  logic [7:0]  radius_q = '0;
  logic [15:0] shape_q = '0;
  draw_mode_t  mode_q = MODE_FILL;

  pixel_result_t pending_pixels[$];
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left = 0;

  always #HALF_PERIOD clk = ~clk;

  aa_circle_coverage_blend_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .x_offset    (x_offset),
    .y_offset    (y_offset),
    .dest_color  (dest_color),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .out_color   (out_color),
    .write_pixel (write_pixel),
    .coverage    (coverage)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor square root, built one root bit at a time from the top
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 15; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // rounded s*a + t*(255-a) over 255 for one color channel
  function automatic int unsigned blend_channel(input int unsigned s, input int unsigned t,
                                                input int unsigned a);
    return (s * a + t * (255 - a) + 127) / 255;
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [7:0] x, input logic [7:0] y,
                                                  input logic [15:0] dest);
    longint unsigned ex;
    longint unsigned ey;
    int              pix_dist;
    int              rq;
    int              delta;
    int              ad;
    int unsigned     cov;
    int unsigned     r;
    int unsigned     g;
    int unsigned     b;
    pixel_result_t   res;
    // distance to the pixel center in 1/16 pixel units
    ex = 2 * longint'(x) + 1;
    ey = 2 * longint'(y) + 1;
    pix_dist = int'(floor_sqrt((ex * ex + ey * ey) << 8) >> 1);
    rq = int'(radius_q) * 16;
    if (mode_q == MODE_FILL) begin
      // two pixel wide ramp across the rim
      delta = rq - pix_dist;
      if (delta >= 16) cov = 255;
      else if (delta <= -16) cov = 0;
      else cov = int'(delta + 16) * 255 / 32;
    end else begin
      // tent centered on the rim
      ad = (pix_dist > rq) ? pix_dist - rq : rq - pix_dist;
      if (ad > 16) cov = 0;
      else cov = 255 - ad * 255 / 16;
    end
    res.cov = cov[7:0];
    res.wr  = (cov != 0);
    if (cov == 0) begin
      res.color = dest;
    end else if (cov == 255) begin
      res.color = shape_q;
    end else begin
      r = blend_channel(shape_q[15:11], dest[15:11], cov);
      g = blend_channel(shape_q[10:5], dest[10:5], cov);
      b = blend_channel(shape_q[4:0], dest[4:0], cov);
      res.color = {r[4:0], g[5:0], b[4:0]};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result monitor: every done beat is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: result beat with nothing pending: color %h wr %b cov %0d",
                   out_color, write_pixel, coverage);
      end else begin
        want = pending_pixels.pop_front();
        if (out_color !== want.color || write_pixel !== want.wr || coverage !== want.cov) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: pixel mismatch: color %h/%h wr %b/%b cov %0d/%0d (want/got)",
                     want.color, out_color, want.wr, write_pixel, want.cov, coverage);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // sends one pixel beat after an idle gap; start stays high for back to back beats
  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic [15:0] dest,
                            input int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    x_offset   <= x;
    y_offset   <= y;
    dest_color <= dest;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(predict_pixel(x, y, dest));
  endtask

  // stop sending and let every pending beat come out
  task automatic drain_pixels();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // register write, only issued with the pipe empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_pixels();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_RADIUS:      radius_q = (data[7:0] > MAX_RADIUS) ? MAX_RADIUS : data[7:0];
      REG_SHAPE_COLOR: shape_q = data;
      REG_DRAW_MODE:   mode_q = draw_mode_t'(data[0]);
      default:         ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // random idle gap, with occasional stretches of back to back beats
  function automatic int unsigned next_gap();
    if (burst_left == 0 && $urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers come out of reset as zero: radius 0, fill, black
  task automatic test_reset_state();
    send_pixel(8'd0, 8'd0, 16'h0000, 0);
    send_pixel(8'd1, 8'd0, 16'hFFFF, 0);
  endtask

  // largest radius: solid center, far corner untouched, blended rim
  task automatic test_fill_large();
    write_reg(REG_RADIUS, 16'd255);
    write_reg(REG_SHAPE_COLOR, 16'hF81F);
    write_reg(REG_DRAW_MODE, {15'd0, MODE_FILL});
    send_pixel(8'd0, 8'd0, 16'h1234, 0);
    send_pixel(8'd255, 8'd255, 16'hABCD, 0);
    send_pixel(8'd255, 8'd0, 16'h07E0, 0);
    send_pixel(8'd180, 8'd180, 16'hFFFF, 2);
  endtask

  // one pixel radius, every pixel lands on the ramp or outside
  task automatic test_fill_tiny();
    write_reg(REG_RADIUS, 16'd1);
    write_reg(REG_SHAPE_COLOR, 16'hFFFF);
    send_pixel(8'd0, 8'd0, 16'h0000, 0);
    send_pixel(8'd1, 8'd0, 16'h0000, 0);
    send_pixel(8'd0, 8'd1, 16'h0000, 1);
    send_pixel(8'd1, 8'd1, 16'h0000, 0);
    send_pixel(8'd2, 8'd0, 16'h0000, 3);
  endtask

  // ring stroke: peak on the rim, zero at the center and far away
  task automatic test_stroke_ring();
    write_reg(REG_RADIUS, 16'd10);
    write_reg(REG_SHAPE_COLOR, 16'h001F);
    write_reg(REG_DRAW_MODE, {15'd0, MODE_STROKE});
    send_pixel(8'd10, 8'd0, 16'hF800, 0);
    send_pixel(8'd9, 8'd0, 16'hF800, 0);
    send_pixel(8'd0, 8'd10, 16'h07E0, 0);
    send_pixel(8'd7, 8'd7, 16'h5555, 0);
    send_pixel(8'd0, 8'd0, 16'hAAAA, 0);
    send_pixel(8'd255, 8'd255, 16'hFFFF, 0);
  endtask

  // a write to the unused index changes nothing; upper data bits are ignored
  task automatic test_unused_index();
    write_reg(REG_SPARE, 16'hFFFF);
    send_pixel(8'd10, 8'd0, 16'h0000, 0);
    write_reg(REG_RADIUS, 16'hFF05);
    write_reg(REG_DRAW_MODE, {15'h7FFF, MODE_FILL});
    send_pixel(8'd5, 8'd0, 16'hFFFF, 0);
  endtask

  // random phases, each with its own configuration and mostly rim pixels
  task automatic test_random_phases();
    int unsigned  r;
    int unsigned  x;
    int unsigned  y;
    int unsigned  tmp;
    logic [15:0]  color;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       r = 0;
        1:       r = 255;
        2:       r = 1;
        default: r = $urandom_range(0, 255);
      endcase
      case (phase % 3)
        0:       color = 16'h0000;
        1:       color = 16'hFFFF;
        default: color = 16'($urandom_range(0, 16'hFFFF));
      endcase
      write_reg(REG_RADIUS, {8'($urandom_range(0, 255)), r[7:0]});
      write_reg(REG_SHAPE_COLOR, color);
      write_reg(REG_DRAW_MODE,
                {15'($urandom_range(0, 16'h7FFF)), (phase % 2 == 0) ? MODE_FILL : MODE_STROKE});
      if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, 16'($urandom_range(0, 16'hFFFF)));
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          // anywhere in the quadrant
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end else begin
          // near the rim: y just around sqrt(r^2 - x^2)
          x = $urandom_range(0, (r < 255) ? r + 1 : 255);
          y = (x <= r) ? int'(floor_sqrt(r * r - x * x)) : 0;
          y = y + $urandom_range(0, 2);
          y = (y == 0) ? 0 : y - 1;
          if (y > 255) y = 255;
          if ($urandom_range(0, 1) == 1) begin
            tmp = x;
            x = y;
            y = tmp;
          end
        end
        send_pixel(x[7:0], y[7:0], 16'($urandom_range(0, 16'hFFFF)), next_gap());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_fill_large();
    test_fill_tiny();
    test_stroke_ring();
    test_unused_index();
    test_random_phases();
    drain_pixels();
    // trailing cycles catch any stray result beat
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
